>>> hdl/mths_pkg.sv
// ----------------------------------------------------------------------------
// mths_pkg: shared types and constants for the monotonic table search
// Table geometry, field widths, transaction structs and sequencer states.
// ----------------------------------------------------------------------------
package mths_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 7;
  localparam int VAL_W       = 32;
  localparam int GUESS_W     = 8;
  localparam int BRACKET_W   = 7;
  // hunt indices reach -1 - 2*TABLE_DEPTH .. 3*TABLE_DEPTH; keep a sign bit
  localparam int IDX_W       = ADDR_W + 3;

  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(TABLE_DEPTH);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(TABLE_DEPTH);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [ADDR_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]   entry_value;
    logic signed [VAL_W-1:0]   search_key;
    logic signed [GUESS_W-1:0] start_guess;
  } in_item_t;

  typedef struct packed {
    logic signed [BRACKET_W-1:0] bracket_index;
    logic                        table_ascending;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic                      start;
    logic signed [VAL_W-1:0]   key;
    logic signed [GUESS_W-1:0] guess;
    logic [LEN_W-1:0]          len;
  } seq_cmd_t;

  typedef struct packed {
    logic                        idle;
    logic                        done;
    logic signed [BRACKET_W-1:0] bracket;
    logic                        asc;
  } seq_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_ASC,
    S_HUNT0,
    S_HUNT_UP,
    S_HUNT_DN,
    S_BIS,
    S_BIS_CMP,
    S_DONE
  } state_t;

endpackage

>>> hdl/mths_table.sv
// ----------------------------------------------------------------------------
// mths_table: table storage
// Single-port write, single-port read memory with registered read data.
// ----------------------------------------------------------------------------
module mths_table (
  input  logic                        clk,
  input  mths_pkg::tbl_wr_t           wr,
  input  mths_pkg::tbl_rd_t           rd,
  output logic [mths_pkg::VAL_W-1:0]  rd_data_r
);

  logic [mths_pkg::VAL_W-1:0] mem [mths_pkg::TABLE_DEPTH];

  // write one entry per write transaction
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, one entry per cycle
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

endmodule

>>> hdl/mths_seq.sv
// ----------------------------------------------------------------------------
// mths_seq: hunt and bisection sequencer
// Drives one table read and one key compare per cycle through the hunt and
// bisection phases, then applies the end-entry equality overrides.
// ----------------------------------------------------------------------------
module mths_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mths_pkg::seq_cmd_t          cmd,
  input  logic                        out_free,
  input  logic [mths_pkg::VAL_W-1:0]  rd_data,
  output mths_pkg::tbl_rd_t           rd,
  output mths_pkg::seq_stat_t         stat
);

  localparam int IDX_W  = mths_pkg::IDX_W;
  localparam int ADDR_W = mths_pkg::ADDR_W;

  mths_pkg::state_t state_r, state_nxt;

  logic signed [mths_pkg::VAL_W-1:0]   key_r, key_nxt;
  logic signed [mths_pkg::GUESS_W-1:0] guess_r, guess_nxt;
  logic [mths_pkg::LEN_W-1:0]          n_r, n_nxt;
  logic signed [mths_pkg::VAL_W-1:0]   last_r, last_nxt;
  logic signed [mths_pkg::VAL_W-1:0]   first_r, first_nxt;
  logic                                asc_r, asc_nxt;
  logic signed [IDX_W-1:0]             lo_r, lo_nxt;
  logic signed [IDX_W-1:0]             hi_r, hi_nxt;
  logic signed [IDX_W-1:0]             step_r, step_nxt;
  logic [ADDR_W-1:0]                   mid_r, mid_nxt;

  logic                    past_w;
  logic signed [IDX_W-1:0] n_s, guess_s, mid_s, step2_w;
  logic signed [IDX_W-1:0] hunt0_up_w, hunt0_dn_w, up_nxt_w, dn_nxt_w;
  logic signed [IDX_W-1:0] bl_w, bh_w, sum_w;
  logic                    wide_w, guess_ok_w;
  logic [ADDR_W-1:0]       mid_w;
  logic signed [IDX_W-1:0] res_w;

  // shared compare unit and index arithmetic
  always_comb begin
    past_w     = ($signed(key_r) >= $signed(rd_data)) == asc_r;
    n_s        = $signed({{(IDX_W-mths_pkg::LEN_W){1'b0}}, n_r});
    guess_s    = $signed({{(IDX_W-mths_pkg::GUESS_W){guess_r[mths_pkg::GUESS_W-1]}},
                          guess_r});
    mid_s      = $signed({{(IDX_W-ADDR_W){1'b0}}, mid_r});
    step2_w    = step_r <<< 1;
    hunt0_up_w = lo_r + IDX_W'(1);
    hunt0_dn_w = lo_r - IDX_W'(1);
    up_nxt_w   = hi_r + step2_w;
    dn_nxt_w   = lo_r - step2_w;
    guess_ok_w = (guess_s >= 0) && (guess_s < n_s);
    // bracket after this cycle's bisection compare
    if (state_r == mths_pkg::S_BIS_CMP) begin
      bl_w = past_w ? mid_s : lo_r;
      bh_w = past_w ? hi_r : mid_s;
    end else begin
      bl_w = lo_r;
      bh_w = hi_r;
    end
    wide_w = (bh_w - bl_w) > IDX_W'(1);
    sum_w  = bh_w + bl_w;
    mid_w  = sum_w[ADDR_W:1];
    // end-entry overrides; the first entry wins
    res_w = lo_r;
    if (key_r == last_r) begin
      res_w = n_s - IDX_W'(2);
    end
    if (key_r == first_r) begin
      res_w = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mths_pkg::S_IDLE: begin
        if (cmd.start) state_nxt = mths_pkg::S_LAST;
      end
      mths_pkg::S_LAST:  state_nxt = mths_pkg::S_FIRST;
      mths_pkg::S_FIRST: state_nxt = mths_pkg::S_ASC;
      mths_pkg::S_ASC: begin
        state_nxt = guess_ok_w ? mths_pkg::S_HUNT0 : mths_pkg::S_BIS;
      end
      mths_pkg::S_HUNT0: begin
        if (past_w) begin
          state_nxt = (hunt0_up_w < n_s) ? mths_pkg::S_HUNT_UP : mths_pkg::S_BIS;
        end else begin
          state_nxt = (hunt0_dn_w >= 0) ? mths_pkg::S_HUNT_DN : mths_pkg::S_BIS;
        end
      end
      mths_pkg::S_HUNT_UP: begin
        state_nxt = (past_w && (up_nxt_w < n_s)) ? mths_pkg::S_HUNT_UP
                                                 : mths_pkg::S_BIS;
      end
      mths_pkg::S_HUNT_DN: begin
        state_nxt = (!past_w && (dn_nxt_w >= 0)) ? mths_pkg::S_HUNT_DN
                                                 : mths_pkg::S_BIS;
      end
      mths_pkg::S_BIS, mths_pkg::S_BIS_CMP: begin
        state_nxt = wide_w ? mths_pkg::S_BIS_CMP : mths_pkg::S_DONE;
      end
      mths_pkg::S_DONE: begin
        if (out_free) state_nxt = mths_pkg::S_IDLE;
      end
      default: state_nxt = mths_pkg::S_IDLE;
    endcase
  end

  // datapath updates and table reads
  always_comb begin
    key_nxt   = key_r;
    guess_nxt = guess_r;
    n_nxt     = n_r;
    last_nxt  = last_r;
    first_nxt = first_r;
    asc_nxt   = asc_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    step_nxt  = step_r;
    mid_nxt   = mid_r;
    rd.en     = 1'b0;
    rd.addr   = '0;
    unique case (state_r)
      mths_pkg::S_IDLE: begin
        if (cmd.start) begin
          key_nxt   = cmd.key;
          guess_nxt = cmd.guess;
          n_nxt     = cmd.len;
        end
      end
      mths_pkg::S_LAST: begin
        rd.en   = 1'b1;
        rd.addr = ADDR_W'(n_r - mths_pkg::LEN_W'(1));
      end
      mths_pkg::S_FIRST: begin
        rd.en    = 1'b1;
        rd.addr  = '0;
        last_nxt = rd_data;
      end
      mths_pkg::S_ASC: begin
        first_nxt = rd_data;
        asc_nxt   = last_r >= $signed(rd_data);
        if (guess_ok_w) begin
          lo_nxt  = guess_s;
          rd.en   = 1'b1;
          rd.addr = guess_s[ADDR_W-1:0];
        end else begin
          lo_nxt = -IDX_W'(1);
          hi_nxt = n_s;
        end
      end
      mths_pkg::S_HUNT0: begin
        step_nxt = IDX_W'(1);
        if (past_w) begin
          hi_nxt = hunt0_up_w;
          if (hunt0_up_w < n_s) begin
            rd.en   = 1'b1;
            rd.addr = hunt0_up_w[ADDR_W-1:0];
          end
        end else begin
          hi_nxt = lo_r;
          lo_nxt = hunt0_dn_w;
          if (hunt0_dn_w >= 0) begin
            rd.en   = 1'b1;
            rd.addr = hunt0_dn_w[ADDR_W-1:0];
          end
        end
      end
      mths_pkg::S_HUNT_UP: begin
        if (past_w) begin
          lo_nxt   = hi_r;
          step_nxt = step2_w;
          if (up_nxt_w < n_s) begin
            hi_nxt  = up_nxt_w;
            rd.en   = 1'b1;
            rd.addr = up_nxt_w[ADDR_W-1:0];
          end else begin
            hi_nxt = n_s;
          end
        end
      end
      mths_pkg::S_HUNT_DN: begin
        if (!past_w) begin
          hi_nxt   = lo_r;
          step_nxt = step2_w;
          if (dn_nxt_w >= 0) begin
            lo_nxt  = dn_nxt_w;
            rd.en   = 1'b1;
            rd.addr = dn_nxt_w[ADDR_W-1:0];
          end else begin
            lo_nxt = -IDX_W'(1);
          end
        end
      end
      mths_pkg::S_BIS, mths_pkg::S_BIS_CMP: begin
        lo_nxt = bl_w;
        hi_nxt = bh_w;
        if (wide_w) begin
          mid_nxt = mid_w;
          rd.en   = 1'b1;
          rd.addr = mid_w;
        end
      end
      mths_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // status toward the top level
  always_comb begin
    stat.idle    = (state_r == mths_pkg::S_IDLE);
    stat.done    = (state_r == mths_pkg::S_DONE);
    stat.bracket = res_w[mths_pkg::BRACKET_W-1:0];
    stat.asc     = asc_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mths_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    guess_r <= guess_nxt;
    n_r     <= n_nxt;
    last_r  <= last_nxt;
    first_r <= first_nxt;
    asc_r   <= asc_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    step_r  <= step_nxt;
    mid_r   <= mid_nxt;
  end

  // every table read stays within the active length
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en |-> ({1'b0, rd.addr} < n_r))
    else $error("table read beyond active length");

  // the pending bisection point lies strictly inside the bracket
  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mths_pkg::S_BIS_CMP) |-> ((lo_r < mid_s) && (mid_s < hi_r)))
    else $error("bisection point outside bracket");

  // the bracket is never empty when bisection starts
  a_bracket_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mths_pkg::S_BIS) |-> (hi_r > lo_r))
    else $error("empty bracket at bisection start");

  // the returned index lies in -1 .. length-1
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> ((res_w >= -IDX_W'(1)) && (res_w < n_s)))
    else $error("bracket index out of range");

endmodule

>>> hdl/monotonic_table_hunt_search_unit.sv
// Timing: a write takes effect at its accepting edge; a search result loads
//   after the setup reads, the hunting and bisecting compares, the bisection
//   entry and the result state.
// Throughput: one write per cycle while the sequencer is idle; a search holds
//   the input until its result loads, which waits on a stalled result register.
// Reset: clears control state and sets table_length to 64; table undefined.
// ----------------------------------------------------------------------------
// monotonic_table_hunt_search_unit: hunt and bisection table search
// Stores a monotonic table and returns the lower bracket index of a key.
// ----------------------------------------------------------------------------
module monotonic_table_hunt_search_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mths_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mths_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [mths_pkg::LEN_W-1:0]      cfg_wr_data
);

  logic [mths_pkg::LEN_W-1:0] len_r;
  logic [mths_pkg::LEN_W-1:0] eff_len;
  logic                       in_accept;
  logic                       out_free;
  logic                       out_valid_r;
  mths_pkg::out_item_t        out_data_r;
  mths_pkg::tbl_wr_t          tbl_wr;
  mths_pkg::tbl_rd_t          tbl_rd;
  logic [mths_pkg::VAL_W-1:0] tbl_rd_data;
  mths_pkg::seq_cmd_t         cmd;
  mths_pkg::seq_stat_t        stat;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= mths_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  // saturate length into the usable range
  always_comb begin
    if (len_r < mths_pkg::LEN_MIN) begin
      eff_len = mths_pkg::LEN_MIN;
    end else if (len_r > mths_pkg::LEN_MAX) begin
      eff_len = mths_pkg::LEN_MAX;
    end else begin
      eff_len = len_r;
    end
  end

  // input transaction: write goes to the table, search starts the sequencer
  always_comb begin
    in_stall     = !stat.idle;
    in_accept    = in_valid && !in_stall;
    tbl_wr.en    = in_accept && (in_data.operation == mths_pkg::OP_WRITE);
    tbl_wr.addr  = in_data.entry_index;
    tbl_wr.data  = in_data.entry_value;
    cmd.start    = in_accept && (in_data.operation == mths_pkg::OP_SEARCH);
    cmd.key      = in_data.search_key;
    cmd.guess    = in_data.start_guess;
    cmd.len      = eff_len;
  end

  mths_table u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd        (tbl_rd),
    .rd_data_r (tbl_rd_data)
  );

  mths_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .out_free (out_free),
    .rd_data  (tbl_rd_data),
    .rd       (tbl_rd),
    .stat     (stat)
  );

  // output register: load a finished result when the slot is free
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stat.done) begin
      out_data_r.bracket_index   <= stat.bracket;
      out_data_r.table_ascending <= stat.asc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
